// ===== sv/aswf_pkg.sv =====
// ----------------------------------------------------------------------------
// aswf_pkg
// Shared types and constants of the auto-ranging scale weight filter.
// ----------------------------------------------------------------------------
`default_nettype none

package aswf_pkg;

  // defaults of the top-level parameters
  localparam int ADC_BITS_DEF  = 10;
  localparam int FRAC_BITS_DEF = 16;

  // field widths
  localparam int CODE_W = 10;
  localparam int UV_W   = 22;
  localparam int MG_W   = 21;
  localparam int CFG_W  = 22;
  localparam int IDX_W  = 3;

  // serial arithmetic widths
  localparam int DIV_N_W = 44;
  localparam int DIV_D_W = 22;
  localparam int MUL_B_W = 22;

  // scaling constants
  localparam logic [UV_W-1:0] FULL_UV     = 22'd3300000;
  localparam logic [14:0]     HYST_MG     = 15'd15000;
  localparam logic [11:0]     ALPHA_NUM   = 12'd3277;
  localparam int              ALPHA_SHIFT = 16;
  localparam logic [15:0]     ALPHA_HALF  = 16'd32768;

  // register indexes
  localparam logic [IDX_W-1:0] REG_FINE_VMIN   = 3'd0;
  localparam logic [IDX_W-1:0] REG_FINE_VMAX   = 3'd1;
  localparam logic [IDX_W-1:0] REG_COARSE_VMIN = 3'd2;
  localparam logic [IDX_W-1:0] REG_COARSE_VMAX = 3'd3;
  localparam logic [IDX_W-1:0] REG_FINE_FS     = 3'd4;
  localparam logic [IDX_W-1:0] REG_COARSE_FS   = 3'd5;

  // register reset values
  localparam logic [UV_W-1:0] RST_VMIN      = 22'd0;
  localparam logic [UV_W-1:0] RST_VMAX      = 22'd3300000;
  localparam logic [MG_W-1:0] RST_FINE_FS   = 21'd290000;
  localparam logic [MG_W-1:0] RST_COARSE_FS = 21'd1040000;

  typedef struct packed {
    logic [CODE_W-1:0] fine_code;
    logic [CODE_W-1:0] coarse_code;
  } in_item_t;

  typedef struct packed {
    logic [MG_W-1:0] filtered_weight_mg;
    logic [UV_W-1:0] measured_volt_uv;
    logic            range_now;
  } out_item_t;

endpackage

`default_nettype wire

// ===== sv/aswf_mul.sv =====
// ----------------------------------------------------------------------------
// aswf_mul
// Bit-serial shift-add multiplier: signed multiplicand, unsigned multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module aswf_mul import aswf_pkg::*; #(
  parameter int A_W = 38,
  parameter int B_W = MUL_B_W
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [A_W-1:0]    a,
  input  logic [B_W-1:0]           b,
  output logic                     done,
  output logic signed [A_W+B_W-1:0] prod
);

  localparam int P_W   = A_W + B_W;
  localparam int CNT_W = $clog2(B_W + 1);

  logic                    busy;
  logic [CNT_W-1:0]        cnt;
  logic signed [P_W-1:0]   mcand;
  logic [B_W-1:0]          mplier;

  // one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= CNT_W'(B_W);
        mcand  <= {{B_W{a[A_W-1]}}, a};
        mplier <= b;
        prod   <= '0;
      end else if (busy) begin
        if (mplier[0]) begin
          prod <= prod + mcand;
        end
        mcand  <= mcand <<< 1;
        mplier <= mplier >> 1;
        cnt    <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/aswf_div.sv =====
// ----------------------------------------------------------------------------
// aswf_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module aswf_div import aswf_pkg::*; #(
  parameter int N_W = DIV_N_W,
  parameter int D_W = DIV_D_W
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           done,
  output logic [N_W-1:0] quot
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [D_W-1:0]   rem;
  logic [D_W-1:0]   den;
  logic [D_W:0]     rem_sh;
  logic [D_W+1:0]   diff;

  // trial subtract of the shifted remainder
  assign rem_sh = {rem, quot[N_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(N_W);
        quot <= dividend;
        den  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        if (!diff[D_W+1]) begin
          rem  <= diff[D_W-1:0];
          quot <= {quot[N_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh[D_W-1:0];
          quot <= {quot[N_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/autorange_scale_weight_filter_unit.sv =====
// ----------------------------------------------------------------------------
// autorange_scale_weight_filter_unit
// Auto-ranging load-cell weight with exponential smoothing.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item carries the fine and coarse ADC codes (valid/ready).
//   out_* : one result item per input item: filtered weight, voltage of the
//           range in use on entry, range after the item (valid/ready).
//   cfg_* : register writes (index, data), always ready; write only while
//           no item is in flight.
// Sequence: one item at a time. Two code-to-voltage divides, one to three
//   serial multiplies, a weight divide (skipped when the weight is zero)
//   and the filter multiply, plus the accept and output steps, all on the
//   shared bit-serial divider and multiplier.
// The output register holds a finished item while the receiver stalls; the
//   next item is taken once that result is loaded.
// Reset: fine range, filter cleared, registers at their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module autorange_scale_weight_filter_unit import aswf_pkg::*; #(
  parameter int ADC_BITS         = ADC_BITS_DEF,
  parameter int FILTER_FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int ACC_W   = MG_W + FILTER_FRAC_BITS;
  localparam int A_W     = ACC_W + 1;
  localparam int P_W     = A_W + MUL_B_W;
  localparam int ADC_TOP = (2 ** ADC_BITS) - 1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_UVF    = 4'd1;
  localparam logic [3:0] S_UVF_W  = 4'd2;
  localparam logic [3:0] S_UVC    = 4'd3;
  localparam logic [3:0] S_UVC_W  = 4'd4;
  localparam logic [3:0] S_NUM    = 4'd5;
  localparam logic [3:0] S_NUM_W  = 4'd6;
  localparam logic [3:0] S_LIM    = 4'd7;
  localparam logic [3:0] S_LIM_W  = 4'd8;
  localparam logic [3:0] S_WDIV   = 4'd9;
  localparam logic [3:0] S_WDIV_W = 4'd10;
  localparam logic [3:0] S_EMA    = 4'd11;
  localparam logic [3:0] S_EMA_W  = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [3:0]        state;
  logic [UV_W-1:0]   fine_vmin, fine_vmax, coarse_vmin, coarse_vmax;
  logic [MG_W-1:0]   fine_fs, coarse_fs;
  logic [CODE_W-1:0] fine_code, coarse_code;
  logic [UV_W-1:0]   uv_f, uv_c;
  logic              active_range, first_range, second;
  logic signed [P_W-1:0] num;
  logic [MG_W-1:0]   wt;
  logic [ACC_W-1:0]  filtered_acc;

  logic [ADC_BITS-1:0]  code_m;
  logic [DIV_N_W-1:0]   uv_dvd, div_dvd, div_quot;
  logic [DIV_D_W-1:0]   div_den;
  logic                 div_start, div_done;
  logic signed [A_W-1:0] mul_a, ema_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic                 mul_start, mul_done;
  logic signed [P_W-1:0] mul_prod, rnd, inc;

  logic [UV_W-1:0]      uv_sel, vmin_sel, vmax_sel, den;
  logic [MG_W-1:0]      fs_sel;
  logic                 empty, w_zero, fine_sw, coarse_sw;
  logic signed [22:0]   a_num, lim;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fine_vmin   <= RST_VMIN;
      fine_vmax   <= RST_VMAX;
      coarse_vmin <= RST_VMIN;
      coarse_vmax <= RST_VMAX;
      fine_fs     <= RST_FINE_FS;
      coarse_fs   <= RST_COARSE_FS;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FINE_VMIN:   fine_vmin   <= cfg_data[UV_W-1:0];
        REG_FINE_VMAX:   fine_vmax   <= cfg_data[UV_W-1:0];
        REG_COARSE_VMIN: coarse_vmin <= cfg_data[UV_W-1:0];
        REG_COARSE_VMAX: coarse_vmax <= cfg_data[UV_W-1:0];
        REG_FINE_FS:     fine_fs     <= cfg_data[MG_W-1:0];
        REG_COARSE_FS:   coarse_fs   <= cfg_data[MG_W-1:0];
        default: ;
      endcase
    end
  end

  // channel of the range in use
  assign uv_sel   = active_range ? uv_c : uv_f;
  assign vmin_sel = active_range ? coarse_vmin : fine_vmin;
  assign vmax_sel = active_range ? coarse_vmax : fine_vmax;
  assign fs_sel   = active_range ? coarse_fs : fine_fs;
  assign empty    = (vmax_sel <= vmin_sel);
  assign den      = vmax_sel - vmin_sel;
  assign a_num    = $signed({1'b0, uv_sel}) - $signed({1'b0, vmin_sel});
  assign lim      = $signed({2'b00, fine_fs}) - $signed({8'd0, HYST_MG});

  // range switch tests
  assign fine_sw   = !empty && (fine_fs != '0) && (uv_f > fine_vmax);
  assign coarse_sw = empty ? (lim > 23'sd0) : (num < mul_prod);
  assign w_zero    = empty || (num <= P_W'(0));

  // divider operands: code to microvolts, or weight
  assign code_m  = ADC_BITS'((state == S_UVF) ? fine_code : coarse_code);
  assign uv_dvd  = DIV_N_W'(code_m) * DIV_N_W'(FULL_UV) + DIV_N_W'(ADC_TOP / 2);
  assign div_dvd = (state == S_WDIV) ? num[DIV_N_W-1:0] : uv_dvd;
  assign div_den = (state == S_WDIV) ? DIV_D_W'(den) : DIV_D_W'(ADC_TOP);
  assign div_start = (state == S_UVF) || (state == S_UVC) ||
                     ((state == S_WDIV) && !w_zero);

  // multiplier operands
  assign ema_a = $signed({1'b0, wt, {FILTER_FRAC_BITS{1'b0}}}) -
                 $signed({1'b0, filtered_acc});
  always_comb begin
    case (state)
      S_LIM: begin
        mul_a = A_W'(lim);
        mul_b = MUL_B_W'(den);
      end
      S_EMA: begin
        mul_a = ema_a;
        mul_b = MUL_B_W'(ALPHA_NUM);
      end
      default: begin
        mul_a = A_W'(a_num);
        mul_b = MUL_B_W'(fs_sel);
      end
    endcase
  end
  assign mul_start = (state == S_NUM) || (state == S_LIM) || (state == S_EMA);

  // filter step: acc + round((w<<F - acc) * alpha)
  assign rnd = mul_prod + P_W'(ALPHA_HALF);
  assign inc = rnd >>> ALPHA_SHIFT;

  aswf_div #(
    .N_W (DIV_N_W),
    .D_W (DIV_D_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_den),
    .done     (div_done),
    .quot     (div_quot)
  );

  aswf_mul #(
    .A_W (A_W),
    .B_W (MUL_B_W)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      active_range <= 1'b0;
      filtered_acc <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            fine_code   <= in_data.fine_code;
            coarse_code <= in_data.coarse_code;
            state       <= S_UVF;
          end
        end
        S_UVF: state <= S_UVF_W;
        S_UVF_W: begin
          if (div_done) begin
            uv_f  <= div_quot[UV_W-1:0];
            state <= S_UVC;
          end
        end
        S_UVC: state <= S_UVC_W;
        S_UVC_W: begin
          if (div_done) begin
            uv_c        <= div_quot[UV_W-1:0];
            first_range <= active_range;
            second      <= 1'b0;
            state       <= S_NUM;
          end
        end
        S_NUM: state <= S_NUM_W;
        S_NUM_W: begin
          if (mul_done) begin
            num <= mul_prod;
            if (second) begin
              state <= S_WDIV;
            end else if (!active_range) begin
              if (fine_sw) begin
                active_range <= 1'b1;
                second       <= 1'b1;
                state        <= S_NUM;
              end else begin
                state <= S_WDIV;
              end
            end else begin
              state <= S_LIM;
            end
          end
        end
        S_LIM: state <= S_LIM_W;
        S_LIM_W: begin
          if (mul_done) begin
            if (coarse_sw) begin
              active_range <= 1'b0;
              second       <= 1'b1;
              state        <= S_NUM;
            end else begin
              state <= S_WDIV;
            end
          end
        end
        S_WDIV: begin
          if (w_zero) begin
            wt    <= '0;
            state <= S_EMA;
          end else begin
            state <= S_WDIV_W;
          end
        end
        S_WDIV_W: begin
          if (div_done) begin
            wt    <= (div_quot > DIV_N_W'(coarse_fs)) ? coarse_fs : div_quot[MG_W-1:0];
            state <= S_EMA;
          end
        end
        S_EMA: state <= S_EMA_W;
        S_EMA_W: begin
          if (mul_done) begin
            filtered_acc <= filtered_acc + inc[ACC_W-1:0];
            state        <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_data.filtered_weight_mg <= filtered_acc[ACC_W-1:FILTER_FRAC_BITS];
            out_data.measured_volt_uv   <= first_range ? uv_c : uv_f;
            out_data.range_now          <= active_range;
            out_valid                   <= 1'b1;
            state                       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in flight");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && (!out_valid || out_ready) |=> out_valid)
    else $error("finished item not presented");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_UVF_W) || (state == S_UVC_W) || (state == S_WDIV_W))
    else $error("divider finished outside a divide step");

  a_mul_owner: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_NUM_W) || (state == S_LIM_W) || (state == S_EMA_W))
    else $error("multiplier finished outside a multiply step");

endmodule

`default_nettype wire
